>>> hdl/dmv_pkg.sv
// Shared constants and types for the dense matrix-vector multiplier.
`default_nettype none

package dmv_pkg;

   localparam int MAX_ORDER   = 4096;
   localparam int ADDR_W      = $clog2(MAX_ORDER);
   localparam int N_W         = $clog2(MAX_ORDER + 1);
   localparam int ORDER_W     = 13;
   localparam int ORDER_RESET = 1024;
   localparam int ORDER_RESET_EFF = (ORDER_RESET > MAX_ORDER) ? MAX_ORDER : ORDER_RESET;
   localparam int VAL_W       = 32;
   localparam int ROW_W       = 12;
   localparam int CHK_W       = 48;
   localparam int ACC_W       = 64;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic KIND_VECTOR = 1'b0;
   localparam logic KIND_MATRIX = 1'b1;

   typedef struct packed {
      logic             end_row;
      logic             last_row;
      logic [ROW_W-1:0] row_index;
   } tag_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] mat_val;
      logic signed [VAL_W-1:0] vec_val;
      tag_type                 tag;
   } item_type;

endpackage

`default_nettype wire

>>> hdl/dmv_front.sv
// Front end: vector store, element counters and operand fetch for matrix words.
`default_nettype none

module dmv_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          cfg_write,
   input  wire logic [dmv_pkg::ORDER_W-1:0]   cfg_order,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_kind,
   input  wire logic signed [dmv_pkg::VAL_W-1:0] req_value,
   output logic                               fr_valid,
   input  wire logic                          fr_ready,
   output dmv_pkg::item_type                  fr_item
);

   logic [dmv_pkg::VAL_W-1:0]  vec_mem [dmv_pkg::MAX_ORDER];

   logic [dmv_pkg::N_W-1:0]    n_ff, n_in;
   logic [dmv_pkg::ADDR_W-1:0] load_ff, load_in;
   logic [dmv_pkg::ADDR_W-1:0] col_ff, col_in;
   logic [dmv_pkg::ADDR_W-1:0] row_ff, row_in;
   logic                       s1_valid_ff, s1_valid_in;
   logic signed [dmv_pkg::VAL_W-1:0] s1_value_ff, s1_value_in;
   dmv_pkg::tag_type           s1_tag_ff, s1_tag_in;
   logic [dmv_pkg::VAL_W-1:0]  rd_data_ff;

   logic accept, load_word, mat_word, col_end, row_end, load_end;

   assign req_ready = !s1_valid_ff || fr_ready;
   assign accept    = req_valid && req_ready;
   assign load_word = accept && (req_kind == dmv_pkg::KIND_VECTOR);
   assign mat_word  = accept && (req_kind == dmv_pkg::KIND_MATRIX);
   assign load_end  = (dmv_pkg::N_W'(load_ff) + dmv_pkg::N_W'(1)) == n_ff;
   assign col_end   = (dmv_pkg::N_W'(col_ff) + dmv_pkg::N_W'(1)) == n_ff;
   assign row_end   = (dmv_pkg::N_W'(row_ff) + dmv_pkg::N_W'(1)) == n_ff;

   always_comb begin
      n_in        = n_ff;
      load_in     = load_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      s1_valid_in = s1_valid_ff;
      s1_value_in = s1_value_ff;
      s1_tag_in   = s1_tag_ff;
      if (s1_valid_ff && fr_ready) begin
         s1_valid_in = 1'b0;
      end
      if (load_word) begin
         load_in = load_end ? '0 : load_ff + dmv_pkg::ADDR_W'(1);
      end
      if (mat_word) begin
         s1_valid_in         = 1'b1;
         s1_value_in         = req_value;
         s1_tag_in.end_row   = col_end;
         s1_tag_in.last_row  = col_end && row_end;
         s1_tag_in.row_index = dmv_pkg::ROW_W'(row_ff);
         col_in = col_end ? '0 : col_ff + dmv_pkg::ADDR_W'(1);
         if (col_end) begin
            row_in = row_end ? '0 : row_ff + dmv_pkg::ADDR_W'(1);
         end
      end
      if (cfg_write) begin
         if (cfg_order == '0) begin
            n_in = dmv_pkg::N_W'(1);
         end else if (32'(cfg_order) > 32'(dmv_pkg::MAX_ORDER)) begin
            n_in = dmv_pkg::N_W'(dmv_pkg::MAX_ORDER);
         end else begin
            n_in = dmv_pkg::N_W'(cfg_order);
         end
         load_in = '0;
         col_in  = '0;
         row_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff        <= dmv_pkg::N_W'(dmv_pkg::ORDER_RESET_EFF);
         load_ff     <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         n_ff        <= n_in;
         load_ff     <= load_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_value_ff <= s1_value_in;
      s1_tag_ff   <= s1_tag_in;
   end

   // vector store: one write or one read per cycle
   always_ff @(posedge clock) begin
      if (load_word) begin
         vec_mem[load_ff] <= req_value;
      end
      if (mat_word) begin
         rd_data_ff <= vec_mem[col_ff];
      end
   end

   assign fr_valid        = s1_valid_ff;
   assign fr_item.mat_val = s1_value_ff;
   assign fr_item.vec_val = $signed(rd_data_ff);
   assign fr_item.tag     = s1_tag_ff;

endmodule

`default_nettype wire

>>> hdl/dmv_queue.sv
// Short FIFO between the front end and the multiply-accumulate back end.
`default_nettype none

module dmv_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire dmv_pkg::item_type in_item,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output dmv_pkg::item_type      out_item
);

   dmv_pkg::item_type           slot_ff [dmv_pkg::QUEUE_DEPTH];
   logic [dmv_pkg::QPTR_W-1:0]  wr_ff, wr_in;
   logic [dmv_pkg::QPTR_W-1:0]  rd_ff, rd_in;
   logic [dmv_pkg::QCNT_W-1:0]  cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready  = cnt_ff != dmv_pkg::QCNT_W'(dmv_pkg::QUEUE_DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_item  = slot_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (32'(wr_ff) == dmv_pkg::QUEUE_DEPTH - 1) ? '0
                                                          : wr_ff + dmv_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_in = (32'(rd_ff) == dmv_pkg::QUEUE_DEPTH - 1) ? '0
                                                          : rd_ff + dmv_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + dmv_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - dmv_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= in_item;
      end
   end

endmodule

`default_nettype wire

>>> hdl/dmv_back.sv
// Back end: multiply, saturating accumulate, rounding, checksum and result register.
`default_nettype none

module dmv_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          cfg_write,
   input  wire logic                          q_valid,
   output logic                               q_ready,
   input  wire dmv_pkg::item_type             q_item,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [dmv_pkg::ROW_W-1:0]          rsp_row_index,
   output logic signed [dmv_pkg::VAL_W-1:0]   rsp_row_result,
   output logic signed [dmv_pkg::CHK_W-1:0]   rsp_checksum,
   output logic                               rsp_last_row
);

   logic go;

   logic                              m_valid_ff, m_valid_in;
   logic signed [dmv_pkg::ACC_W-1:0]  m_prod_ff, m_prod_in;
   dmv_pkg::tag_type                  m_tag_ff, m_tag_in;

   logic signed [dmv_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic                              a_valid_ff, a_valid_in;
   logic signed [dmv_pkg::ACC_W-1:0]  a_acc_ff, a_acc_in;
   dmv_pkg::tag_type                  a_tag_ff, a_tag_in;

   logic                              r_valid_ff, r_valid_in;
   logic signed [dmv_pkg::VAL_W-1:0]  r_res_ff, r_res_in;
   dmv_pkg::tag_type                  r_tag_ff, r_tag_in;

   logic signed [dmv_pkg::CHK_W-1:0]  chk_ff, chk_in;
   logic                              out_valid_ff, out_valid_in;
   logic [dmv_pkg::ROW_W-1:0]         out_row_ff, out_row_in;
   logic signed [dmv_pkg::VAL_W-1:0]  out_res_ff, out_res_in;
   logic signed [dmv_pkg::CHK_W-1:0]  out_chk_ff, out_chk_in;
   logic                              out_last_ff, out_last_in;

   logic [dmv_pkg::ACC_W:0]           acc_sum;
   logic signed [dmv_pkg::ACC_W-1:0]  acc_sat;
   logic [dmv_pkg::ACC_W:0]           rnd_sum;
   logic [dmv_pkg::ACC_W-16:0]        rnd_q;
   logic [dmv_pkg::CHK_W:0]           chk_sum;
   logic signed [dmv_pkg::CHK_W-1:0]  chk_sat;

   assign go      = !out_valid_ff || rsp_ready;
   assign q_ready = go;

   // saturating 64-bit accumulate
   always_comb begin
      acc_sum = {acc_ff[dmv_pkg::ACC_W-1], acc_ff} + {m_prod_ff[dmv_pkg::ACC_W-1], m_prod_ff};
      if (acc_sum[dmv_pkg::ACC_W] != acc_sum[dmv_pkg::ACC_W-1]) begin
         acc_sat = acc_sum[dmv_pkg::ACC_W] ? {1'b1, {(dmv_pkg::ACC_W-1){1'b0}}}
                                           : {1'b0, {(dmv_pkg::ACC_W-1){1'b1}}};
      end else begin
         acc_sat = $signed(acc_sum[dmv_pkg::ACC_W-1:0]);
      end
   end

   // Q32.32 -> Q16.16, round half up, saturate to 32 bits
   always_comb begin
      rnd_sum = {a_acc_ff[dmv_pkg::ACC_W-1], a_acc_ff} + (dmv_pkg::ACC_W+1)'(32768);
      rnd_q   = rnd_sum[dmv_pkg::ACC_W:16];
      if (rnd_q[dmv_pkg::ACC_W-16:dmv_pkg::VAL_W-1] != '0 &&
          rnd_q[dmv_pkg::ACC_W-16:dmv_pkg::VAL_W-1] != '1) begin
         r_res_in = rnd_q[dmv_pkg::ACC_W-16] ? {1'b1, {(dmv_pkg::VAL_W-1){1'b0}}}
                                             : {1'b0, {(dmv_pkg::VAL_W-1){1'b1}}};
      end else begin
         r_res_in = $signed(rnd_q[dmv_pkg::VAL_W-1:0]);
      end
   end

   // saturating 48-bit checksum
   always_comb begin
      chk_sum = {chk_ff[dmv_pkg::CHK_W-1], chk_ff}
              + {{(dmv_pkg::CHK_W+1-dmv_pkg::VAL_W){r_res_ff[dmv_pkg::VAL_W-1]}}, r_res_ff};
      if (chk_sum[dmv_pkg::CHK_W] != chk_sum[dmv_pkg::CHK_W-1]) begin
         chk_sat = chk_sum[dmv_pkg::CHK_W] ? {1'b1, {(dmv_pkg::CHK_W-1){1'b0}}}
                                           : {1'b0, {(dmv_pkg::CHK_W-1){1'b1}}};
      end else begin
         chk_sat = $signed(chk_sum[dmv_pkg::CHK_W-1:0]);
      end
   end

   always_comb begin
      m_valid_in   = m_valid_ff;
      m_prod_in    = m_prod_ff;
      m_tag_in     = m_tag_ff;
      acc_in       = acc_ff;
      a_valid_in   = a_valid_ff;
      a_acc_in     = a_acc_ff;
      a_tag_in     = a_tag_ff;
      r_valid_in   = r_valid_ff;
      r_tag_in     = r_tag_ff;
      chk_in       = chk_ff;
      out_valid_in = out_valid_ff;
      out_row_in   = out_row_ff;
      out_res_in   = out_res_ff;
      out_chk_in   = out_chk_ff;
      out_last_in  = out_last_ff;
      if (go) begin
         m_valid_in = q_valid;
         m_prod_in  = q_item.mat_val * q_item.vec_val;
         m_tag_in   = q_item.tag;

         a_valid_in = m_valid_ff && m_tag_ff.end_row;
         a_acc_in   = acc_sat;
         a_tag_in   = m_tag_ff;
         if (m_valid_ff) begin
            acc_in = m_tag_ff.end_row ? '0 : acc_sat;
         end

         r_valid_in = a_valid_ff;
         r_tag_in   = a_tag_ff;

         out_valid_in = r_valid_ff;
         out_row_in   = r_tag_ff.row_index;
         out_res_in   = r_res_ff;
         out_chk_in   = chk_sat;
         out_last_in  = r_tag_ff.last_row;
         if (r_valid_ff) begin
            chk_in = r_tag_ff.last_row ? '0 : chk_sat;
         end
      end
      if (cfg_write) begin
         acc_in = '0;
         chk_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff   <= 1'b0;
         a_valid_ff   <= 1'b0;
         r_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         acc_ff       <= '0;
         chk_ff       <= '0;
      end else begin
         m_valid_ff   <= m_valid_in;
         a_valid_ff   <= a_valid_in;
         r_valid_ff   <= r_valid_in;
         out_valid_ff <= out_valid_in;
         acc_ff       <= acc_in;
         chk_ff       <= chk_in;
      end
   end

   always_ff @(posedge clock) begin
      m_prod_ff   <= m_prod_in;
      m_tag_ff    <= m_tag_in;
      a_acc_ff    <= a_acc_in;
      a_tag_ff    <= a_tag_in;
      if (go) begin
         r_res_ff <= r_res_in;
      end
      r_tag_ff    <= r_tag_in;
      out_row_ff  <= out_row_in;
      out_res_ff  <= out_res_in;
      out_chk_ff  <= out_chk_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_row_index  = out_row_ff;
   assign rsp_row_result = out_res_ff;
   assign rsp_checksum   = out_chk_ff;
   assign rsp_last_row   = out_last_ff;

endmodule

`default_nettype wire

>>> hdl/dense_matrix_vector_multiply.sv
// Top level of the dense matrix-vector multiplier y = A*x in Q16.16.
// Takes one word per cycle unless stalled, vector loads and matrix elements alike, and
// emits one result word at the end of each matrix row. A front end writes vector words
// into a 4096 x 32 vector store and, for each matrix word, reads the stored element of
// its column in the same cycle; a four-entry queue then feeds the back end, which does
// one 32x32 multiply and one 64-bit saturating add per cycle unless the result is
// stalled, then rounds and saturates the row sum and updates the 48-bit checksum.
// Throughput is set by the single multiply-accumulate unit and the
// one-access-per-cycle vector store. Writing csr_order sets the order, clears all
// counters and accumulators and keeps the vector store; write it only while no words
// are in flight. Unwritten vector entries read as unknown.
`default_nettype none

module dense_matrix_vector_multiply (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [dmv_pkg::ORDER_W-1:0]        csr_order,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_kind,
   input  wire logic signed [dmv_pkg::VAL_W-1:0]   req_value,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [dmv_pkg::ROW_W-1:0]               rsp_row_index,
   output logic signed [dmv_pkg::VAL_W-1:0]        rsp_row_result,
   output logic signed [dmv_pkg::CHK_W-1:0]        rsp_checksum,
   output logic                                    rsp_last_row
);

   logic              cfg_write;
   logic              fr_valid, fr_ready;
   dmv_pkg::item_type fr_item;
   logic              q_valid, q_ready;
   dmv_pkg::item_type q_item;

   assign csr_ready = 1'b1;
   assign cfg_write = csr_valid && csr_ready;

   dmv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg_write (cfg_write),
      .cfg_order (csr_order),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .req_value (req_value),
      .fr_valid  (fr_valid),
      .fr_ready  (fr_ready),
      .fr_item   (fr_item)
   );

   dmv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_item   (fr_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   dmv_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg_write      (cfg_write),
      .q_valid        (q_valid),
      .q_ready        (q_ready),
      .q_item         (q_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_row_index  (rsp_row_index),
      .rsp_row_result (rsp_row_result),
      .rsp_checksum   (rsp_checksum),
      .rsp_last_row   (rsp_last_row)
   );

endmodule

`default_nettype wire

>>> sim/tb_dense_matrix_vector_multiply.sv
// Self-checking testbench for the dense matrix-vector multiplier.
`timescale 1ns / 100ps

module tb_dense_matrix_vector_multiply;

   localparam int unsigned RANDOM_WORDS  = 930;
   localparam int unsigned SETTLE_CYCLES = 24;
   localparam int unsigned STUCK_LIMIT   = 2000;

   typedef struct packed {
      logic [dmv_pkg::ROW_W-1:0]        row_index;
      logic signed [dmv_pkg::VAL_W-1:0] row_result;
      logic signed [dmv_pkg::CHK_W-1:0] checksum;
      logic                             last_row;
   } row_result_type;

   typedef struct packed {
      logic                      is_cfg;
      logic                      kind;
      logic [dmv_pkg::VAL_W-1:0] value;
      logic                      typed;
      row_result_type            row;
   } directed_row_type;

   localparam row_result_type NO_ROW = '0;

   // cfg rows carry the order in value; typed rows carry their expected row result
   localparam directed_row_type DIRECTED_ROWS [0:21] = '{
      '{1'b1, 1'b0, 32'd0, 1'b0, NO_ROW},
      '{1'b0, dmv_pkg::KIND_VECTOR, 32'h0001_0000, 1'b0, NO_ROW},
      '{1'b0, dmv_pkg::KIND_MATRIX, 32'h0001_0000, 1'b1,
        '{12'd0, 32'h0001_0000, 48'h0000_0001_0000, 1'b1}},
      '{1'b0, dmv_pkg::KIND_MATRIX, 32'h7FFF_FFFF, 1'b1,
        '{12'd0, 32'h7FFF_FFFF, 48'h0000_7FFF_FFFF, 1'b1}},
      '{1'b0, dmv_pkg::KIND_MATRIX, 32'h8000_0000, 1'b1,
        '{12'd0, 32'h8000_0000, 48'hFFFF_8000_0000, 1'b1}},
      '{1'b0, dmv_pkg::KIND_VECTOR, 32'h0000_0001, 1'b0, NO_ROW},
      '{1'b0, dmv_pkg::KIND_MATRIX, 32'h0000_8000, 1'b1,
        '{12'd0, 32'h0000_0001, 48'h0000_0000_0001, 1'b1}},
      '{1'b0, dmv_pkg::KIND_MATRIX, 32'hFFFF_8000, 1'b1,
        '{12'd0, 32'h0000_0000, 48'h0000_0000_0000, 1'b1}},
      '{1'b0, dmv_pkg::KIND_MATRIX, 32'hFFFF_7FFF, 1'b1,
        '{12'd0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1}},
      '{1'b0, dmv_pkg::KIND_MATRIX, 32'h0000_0000, 1'b1,
        '{12'd0, 32'h0000_0000, 48'h0000_0000_0000, 1'b1}},
      '{1'b1, 1'b0, 32'd1, 1'b0, NO_ROW},
      '{1'b0, dmv_pkg::KIND_MATRIX, 32'hFFFF_FFFF, 1'b1,
        '{12'd0, 32'h0000_0000, 48'h0000_0000_0000, 1'b1}},
      '{1'b1, 1'b0, 32'd2, 1'b0, NO_ROW},
      '{1'b0, dmv_pkg::KIND_VECTOR, 32'h8000_0000, 1'b0, NO_ROW},
      '{1'b0, dmv_pkg::KIND_VECTOR, 32'h8000_0000, 1'b0, NO_ROW},
      '{1'b0, dmv_pkg::KIND_MATRIX, 32'h8000_0000, 1'b0, NO_ROW},
      '{1'b0, dmv_pkg::KIND_MATRIX, 32'h8000_0000, 1'b1,
        '{12'd0, 32'h7FFF_FFFF, 48'h0000_7FFF_FFFF, 1'b0}},
      '{1'b0, dmv_pkg::KIND_MATRIX, 32'h7FFF_FFFF, 1'b0, NO_ROW},
      '{1'b0, dmv_pkg::KIND_MATRIX, 32'h7FFF_FFFF, 1'b1,
        '{12'd1, 32'h8000_0000, 48'hFFFF_FFFF_FFFF, 1'b1}},
      '{1'b0, dmv_pkg::KIND_VECTOR, 32'h0001_8000, 1'b0, NO_ROW},
      '{1'b0, dmv_pkg::KIND_MATRIX, 32'h0002_0000, 1'b0, NO_ROW},
      '{1'b0, dmv_pkg::KIND_MATRIX, 32'hFFFF_FFFF, 1'b0, NO_ROW}
   };

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [dmv_pkg::ORDER_W-1:0]        csr_order = '0;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic                               req_kind = dmv_pkg::KIND_VECTOR;
   logic signed [dmv_pkg::VAL_W-1:0]   req_value = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic [dmv_pkg::ROW_W-1:0]          rsp_row_index;
   logic signed [dmv_pkg::VAL_W-1:0]   rsp_row_result;
   logic signed [dmv_pkg::CHK_W-1:0]   rsp_checksum;
   logic                               rsp_last_row;

   // travels with the request word: typed expectation for directed rows
   logic                               req_typed = 1'b0;
   row_result_type                     req_typed_row = '0;

   // model of the block
   logic [dmv_pkg::ORDER_W-1:0]        order_reg = dmv_pkg::ORDER_W'(dmv_pkg::ORDER_RESET);
   logic signed [dmv_pkg::VAL_W-1:0]   vector_mem [dmv_pkg::MAX_ORDER];
   int unsigned                        load_idx, column_idx, row_idx;
   logic signed [dmv_pkg::ACC_W-1:0]   row_acc = '0;
   logic signed [dmv_pkg::CHK_W-1:0]   checksum_acc = '0;
   row_result_type                     rows_due [$];
   row_result_type                     predicted_row;
   int unsigned                        fail_count;

   // stimulus-side view of the counters, so matrix words never read an unloaded entry
   bit                                 loaded [dmv_pkg::MAX_ORDER];
   int unsigned                        stim_order, stim_load, stim_column;
   int unsigned                        words_sent, calm_words;

   int unsigned                        stall_left, calm_cycles, stuck_cycles;

   dense_matrix_vector_multiply u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_order      (csr_order),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_row_index  (rsp_row_index),
      .rsp_row_result (rsp_row_result),
      .rsp_checksum   (rsp_checksum),
      .rsp_last_row   (rsp_last_row)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int unsigned effective_order(
         input logic [dmv_pkg::ORDER_W-1:0] order);
      if (order == 0)
         return 1;
      if (order > dmv_pkg::MAX_ORDER)
         return dmv_pkg::MAX_ORDER;
      return 32'(order);
   endfunction

   // one word into the multiply-accumulate model; returns 1 when a row completes
   function automatic bit accumulate_word(input logic kind,
                                          input logic signed [dmv_pkg::VAL_W-1:0] value,
                                          output row_result_type row);
      int unsigned                         n;
      logic signed [dmv_pkg::ACC_W-1:0]    product;
      logic [dmv_pkg::ACC_W:0]             sum;
      logic signed [dmv_pkg::ACC_W:0]      rounded;
      logic signed [dmv_pkg::VAL_W-1:0]    result;
      logic [dmv_pkg::CHK_W:0]             chk_sum;
      n = effective_order(order_reg);
      row = '0;
      if (load_idx >= n) load_idx = 0;
      if (column_idx >= n) column_idx = 0;
      if (row_idx >= n) row_idx = 0;
      if (kind == dmv_pkg::KIND_VECTOR) begin
         vector_mem[load_idx] = value;
         load_idx = (load_idx + 1 >= n) ? 0 : load_idx + 1;
         return 1'b0;
      end
      product = value * vector_mem[column_idx];
      sum = {row_acc[dmv_pkg::ACC_W-1], row_acc} + {product[dmv_pkg::ACC_W-1], product};
      if (sum[dmv_pkg::ACC_W] != sum[dmv_pkg::ACC_W-1])
         row_acc = sum[dmv_pkg::ACC_W] ? {1'b1, {(dmv_pkg::ACC_W-1){1'b0}}}
                                       : {1'b0, {(dmv_pkg::ACC_W-1){1'b1}}};
      else
         row_acc = sum[dmv_pkg::ACC_W-1:0];
      column_idx++;
      if (column_idx < n)
         return 1'b0;
      column_idx = 0;
      // round half up to Q16.16, then saturate to 32 bits
      rounded = {row_acc[dmv_pkg::ACC_W-1], row_acc} + 65'd32768;
      rounded = rounded >>> 16;
      if (rounded[dmv_pkg::ACC_W:dmv_pkg::VAL_W-1] !=
          {(dmv_pkg::ACC_W-dmv_pkg::VAL_W+2){rounded[dmv_pkg::ACC_W]}})
         result = rounded[dmv_pkg::ACC_W] ? {1'b1, {(dmv_pkg::VAL_W-1){1'b0}}}
                                          : {1'b0, {(dmv_pkg::VAL_W-1){1'b1}}};
      else
         result = rounded[dmv_pkg::VAL_W-1:0];
      row_acc = '0;
      chk_sum = {checksum_acc[dmv_pkg::CHK_W-1], checksum_acc}
              + {{(dmv_pkg::CHK_W-dmv_pkg::VAL_W+1){result[dmv_pkg::VAL_W-1]}}, result};
      if (chk_sum[dmv_pkg::CHK_W] != chk_sum[dmv_pkg::CHK_W-1])
         checksum_acc = chk_sum[dmv_pkg::CHK_W] ? {1'b1, {(dmv_pkg::CHK_W-1){1'b0}}}
                                                : {1'b0, {(dmv_pkg::CHK_W-1){1'b1}}};
      else
         checksum_acc = chk_sum[dmv_pkg::CHK_W-1:0];
      row.row_index  = dmv_pkg::ROW_W'(row_idx);
      row.row_result = result;
      row.checksum   = checksum_acc;
      row.last_row   = (row_idx + 1 >= n);
      if (row.last_row) begin
         row_idx = 0;
         checksum_acc = '0;
      end else begin
         row_idx++;
      end
      return 1'b1;
   endfunction

   function automatic void check_row(input row_result_type got);
      row_result_type want;
      if (rows_due.size() == 0) begin
         $error("row result with nothing expected: row_index %0d", got.row_index);
         fail_count++;
         return;
      end
      want = rows_due.pop_front();
      if (got.row_index !== want.row_index) begin
         $error("row_index: expected %0d, got %0d", want.row_index, got.row_index);
         fail_count++;
      end
      if (got.row_result !== want.row_result) begin
         $error("row_result: expected %h, got %h", want.row_result, got.row_result);
         fail_count++;
      end
      if (got.checksum !== want.checksum) begin
         $error("checksum: expected %h, got %h", want.checksum, got.checksum);
         fail_count++;
      end
      if (got.last_row !== want.last_row) begin
         $error("last_row: expected %0d, got %0d", want.last_row, got.last_row);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            order_reg    = csr_order;
            load_idx     = 0;
            column_idx   = 0;
            row_idx      = 0;
            row_acc      = '0;
            checksum_acc = '0;
         end
         if (rsp_valid && rsp_ready)
            check_row('{rsp_row_index, rsp_row_result, rsp_checksum, rsp_last_row});
         if (req_valid && req_ready) begin
            if (accumulate_word(req_kind, req_value, predicted_row))
               rows_due.push_back(req_typed ? req_typed_row : predicted_row);
         end
      end
   end

   // result side back-pressure: short and long stalls, with calm stretches
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         if (calm_cycles > 0) begin
            calm_cycles--;
         end else begin
            case ($urandom_range(0, 99))
               0, 1, 2, 3, 4, 5, 6, 7, 8, 9: stall_left = $urandom_range(1, 3);
               10, 11, 12: stall_left = $urandom_range(10, 50);
               13, 14: calm_cycles = $urandom_range(50, 200);
               default: ;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles == STUCK_LIMIT) begin
         $display("FAIL dense_matrix_vector_multiply");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   function automatic logic [dmv_pkg::VAL_W-1:0] random_value();
      logic [19:0] low_bits;
      low_bits = 20'($urandom());
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3, 4: return $urandom();
         default: return {{12{low_bits[19]}}, low_bits};
      endcase
   endfunction

   task automatic push_word(input logic kind, input logic [dmv_pkg::VAL_W-1:0] value,
                            input logic typed, input row_result_type typed_row);
      int unsigned gap;
      int unsigned pick;
      logic        word_kind;
      word_kind = kind;
      if (word_kind == dmv_pkg::KIND_MATRIX && !loaded[stim_column])
         word_kind = dmv_pkg::KIND_VECTOR;
      if (word_kind == dmv_pkg::KIND_VECTOR) begin
         loaded[stim_load] = 1'b1;
         stim_load = (stim_load + 1 == stim_order) ? 0 : stim_load + 1;
      end else begin
         stim_column = (stim_column + 1 == stim_order) ? 0 : stim_column + 1;
      end
      gap = 0;
      if (calm_words > 0) begin
         calm_words--;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick <= 2)
            calm_words = $urandom_range(30, 150);
         else if (pick <= 54)
            gap = 0;
         else if (pick <= 91)
            gap = $urandom_range(1, 3);
         else
            gap = $urandom_range(8, 40);
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= word_kind;
      req_value     <= value;
      req_typed     <= typed;
      req_typed_row <= typed_row;
      words_sent++;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (rows_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_order(input logic [dmv_pkg::ORDER_W-1:0] order);
      wait_drained();
      csr_valid <= 1'b1;
      csr_order <= order;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      stim_order  = effective_order(order);
      stim_load   = 0;
      stim_column = 0;
   endtask

   initial begin
      int unsigned   random_start, rows, count;
      logic [dmv_pkg::ORDER_W-1:0] order;
      stim_order = effective_order(dmv_pkg::ORDER_W'(dmv_pkg::ORDER_RESET));
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         if (DIRECTED_ROWS[i].is_cfg)
            write_order(DIRECTED_ROWS[i].value[dmv_pkg::ORDER_W-1:0]);
         else
            push_word(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].value,
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].row);
      end

      random_start = words_sent;
      while (words_sent - random_start < RANDOM_WORDS) begin
         case ($urandom_range(0, 19))
            0: order = '0;
            1: order = dmv_pkg::ORDER_W'(1);
            16, 17: order = dmv_pkg::ORDER_W'($urandom_range(9, 16));
            18: order = dmv_pkg::ORDER_W'($urandom_range(17, 40));
            default: order = dmv_pkg::ORDER_W'($urandom_range(2, 8));
         endcase
         write_order(order);
         repeat (stim_order)
            push_word(dmv_pkg::KIND_VECTOR, random_value(), 1'b0, NO_ROW);
         if ($urandom_range(0, 4) != 0) begin
            // whole rows, several matrices when rows exceed the order
            rows = $urandom_range(1, (stim_order <= 16) ? stim_order + 2 : 2);
            repeat (rows * stim_order)
               push_word(($urandom_range(0, 99) < 3) ? dmv_pkg::KIND_VECTOR
                                                     : dmv_pkg::KIND_MATRIX,
                         random_value(), 1'b0, NO_ROW);
         end else begin
            // broken rows and heavy reloads
            count = $urandom_range(1, 3 * stim_order + 2);
            repeat (count)
               push_word(($urandom_range(0, 9) < 3) ? dmv_pkg::KIND_VECTOR
                                                    : dmv_pkg::KIND_MATRIX,
                         random_value(), 1'b0, NO_ROW);
         end
      end

      wait_drained();
      if (fail_count == 0)
         $display("PASS dense_matrix_vector_multiply");
      else
         $display("FAIL dense_matrix_vector_multiply");
      $finish;
   end

endmodule
